### hw/rtl/rsp_pkg.sv
package rsp_pkg;

    localparam int MOD_W    = 61;
    localparam int COEF_W   = 64;
    localparam int WORD_W   = 32;
    localparam int EXP_W    = 2 * WORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_MODULI = 4;
    localparam int MIDX_W   = 2;
    localparam int BIT_W    = $clog2(COEF_W);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LOG_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_POWER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_THREE = 3'd5;

    // Top bit positions for the two kinds of operation on the shared unit.
    localparam logic [BIT_W-1:0] TOP_FULL   = BIT_W'(COEF_W - 1);
    localparam logic [BIT_W-1:0] TOP_RESIDUE = BIT_W'(MOD_W - 1);

    typedef struct packed {
        logic             start;
        logic [BIT_W-1:0] top_bit;
    } mm_ctrl_t;

endpackage

### hw/rtl/rsp_mulmod_unit.sv
module rsp_mulmod_unit
    import rsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mm_ctrl_t          ctrl,
    input  logic [MOD_W-1:0]  op_a,
    input  logic [COEF_W-1:0] op_b,
    input  logic [MOD_W-1:0]  modulus,
    output logic              done,
    output logic [MOD_W-1:0]  result
);

    logic              busy_reg;
    logic              done_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic [MOD_W-1:0]  r_reg;
    logic [MOD_W-1:0]  a_reg;
    logic [COEF_W-1:0] b_reg;

    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    dbl_red;
    logic [MOD_W:0]    sum;
    logic [MOD_W:0]    sum_red;
    logic [MOD_W-1:0]  r_next;

    // One bit of the multiplier per cycle, most significant first:
    // r = 2r mod m, then r = r + a mod m where the bit is set.
    always_comb
    begin
        dbl = {r_reg, 1'b0};
        if (dbl >= {1'b0, modulus})
        begin
            dbl_red = dbl - {1'b0, modulus};
        end
        else
        begin
            dbl_red = dbl;
        end
        sum = dbl_red + {1'b0, a_reg};
        if (sum >= {1'b0, modulus})
        begin
            sum_red = sum - {1'b0, modulus};
        end
        else
        begin
            sum_red = sum;
        end
        if (b_reg[bit_reg])
        begin
            r_next = sum_red[MOD_W-1:0];
        end
        else
        begin
            r_next = dbl_red[MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
            r_reg    <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= ctrl.top_bit;
                r_reg    <= '0;
                a_reg    <= op_a;
                b_reg    <= op_b;
            end
            else if (busy_reg)
            begin
                r_reg <= r_next;
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

### hw/rtl/rns_scale_by_power_of_two_unit.sv
// Scales one RNS coefficient per request by 2^(log_base*digit_power) modulo the
// modulus that modulus_index selects, returning exactly one result per request.
// All arithmetic runs on one shift-and-add modular multiplier that handles one
// bit per cycle, so that unit sets the pace while the output does not stall: a
// coefficient whose factor is cached is reduced modulo the modulus and then
// multiplied by the factor. The first coefficient of a modulus after reset or
// any write to a known register also computes the factor by square-and-multiply
// first. An exponent beyond 32 bits, or a modulus below two, gives a zero
// result, and the former raises shift_error. The next request is taken as soon
// as the previous result has been moved to the output register.
module rns_scale_by_power_of_two_unit
    import rsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MOD_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [COEF_W-1:0]    coefficient,
    input  logic [MIDX_W-1:0]    modulus_index,
    input  logic                 last_of_poly,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MOD_W-1:0]     scaled,
    output logic                 shift_error,
    output logic                 last_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REDUCE,
        S_POW_TEST,
        S_POW_MUL,
        S_POW_SQR,
        S_SCALE,
        S_DONE
    } state_t;

    state_t               state_reg,    state_next;
    logic [WORD_W-1:0]    log_base_reg, log_base_next;
    logic [WORD_W-1:0]    power_reg,    power_next;
    logic [MOD_W-1:0]     mod_reg       [NUM_MODULI];
    logic [MOD_W-1:0]     mod_next      [NUM_MODULI];
    logic [MOD_W-1:0]     cache_reg     [NUM_MODULI];
    logic [MOD_W-1:0]     cache_next    [NUM_MODULI];
    logic [NUM_MODULI-1:0] fvalid_reg,  fvalid_next;

    logic [COEF_W-1:0]    coef_reg,     coef_next;
    logic [MIDX_W-1:0]    idx_reg,      idx_next;
    logic                 last_reg,     last_next;
    logic [EXP_W-1:0]     exp_reg,      exp_next;
    logic [MOD_W-1:0]     coefmod_reg,  coefmod_next;
    logic [MOD_W-1:0]     acc_reg,      acc_next;
    logic [MOD_W-1:0]     base_reg,     base_next;
    logic [WORD_W-1:0]    e_reg,        e_next;
    logic [MOD_W-1:0]     res_reg,      res_next;
    logic                 err_reg,      err_next;

    mm_ctrl_t             mm_ctrl_reg,  mm_ctrl_next;
    logic [MOD_W-1:0]     mm_a_reg,     mm_a_next;
    logic [COEF_W-1:0]    mm_b_reg,     mm_b_next;
    logic                 mm_done;
    logic [MOD_W-1:0]     mm_result;

    logic                 out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]     scaled_reg,   scaled_next;
    logic                 shift_error_reg, shift_error_next;
    logic                 last_out_reg, last_out_next;

    logic [MOD_W-1:0]     cur_mod;
    logic [MIDX_W-1:0]    cfg_mod_sel;
    logic [MIDX_W-1:0]    in_idx;

    assign cur_mod     = mod_reg[idx_reg];
    assign cfg_mod_sel = MIDX_W'(cfg_index - REG_MODULUS_ZERO);
    assign in_idx      = (int'(modulus_index) >= NUM_MODULI) ?
                         MIDX_W'(NUM_MODULI - 1) : modulus_index;

    rsp_mulmod_unit u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mm_ctrl_reg),
        .op_a    (mm_a_reg),
        .op_b    (mm_b_reg),
        .modulus (cur_mod),
        .done    (mm_done),
        .result  (mm_result)
    );

    always_comb
    begin
        state_next       = state_reg;
        log_base_next    = log_base_reg;
        power_next       = power_reg;
        mod_next         = mod_reg;
        cache_next       = cache_reg;
        fvalid_next      = fvalid_reg;
        coef_next        = coef_reg;
        idx_next         = idx_reg;
        last_next        = last_reg;
        exp_next         = exp_reg;
        coefmod_next     = coefmod_reg;
        acc_next         = acc_reg;
        base_next        = base_reg;
        e_next           = e_reg;
        res_next         = res_reg;
        err_next         = err_reg;
        mm_ctrl_next     = '{start: 1'b0, top_bit: mm_ctrl_reg.top_bit};
        mm_a_next        = mm_a_reg;
        mm_b_next        = mm_b_reg;
        out_valid_next   = out_valid_reg;
        scaled_next      = scaled_reg;
        shift_error_next = shift_error_reg;
        last_out_next    = last_out_reg;

        // Any write to a known register invalidates every cached factor.
        if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_LOG_BASE:
                begin
                    log_base_next = cfg_data[WORD_W-1:0];
                    fvalid_next   = '0;
                end
                REG_DIGIT_POWER:
                begin
                    power_next  = cfg_data[WORD_W-1:0];
                    fvalid_next = '0;
                end
                REG_MODULUS_ZERO, REG_MODULUS_ONE, REG_MODULUS_TWO, REG_MODULUS_THREE:
                begin
                    mod_next[cfg_mod_sel] = cfg_data;
                    fvalid_next           = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    coef_next  = coefficient;
                    idx_next   = in_idx;
                    last_next  = last_of_poly;
                    exp_next   = EXP_W'(log_base_reg) * EXP_W'(power_reg);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (exp_reg[EXP_W-1:WORD_W] != '0)
                begin
                    res_next   = '0;
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (cur_mod < MOD_W'(2))
                begin
                    res_next   = '0;
                    err_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    // Multiplying by one reduces the coefficient modulo m.
                    mm_ctrl_next = '{start: 1'b1, top_bit: TOP_FULL};
                    mm_a_next    = MOD_W'(1);
                    mm_b_next    = coef_reg;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    coefmod_next = mm_result;
                    if (fvalid_reg[idx_reg])
                    begin
                        mm_ctrl_next = '{start: 1'b1, top_bit: TOP_RESIDUE};
                        mm_a_next    = mm_result;
                        mm_b_next    = COEF_W'(cache_reg[idx_reg]);
                        state_next   = S_SCALE;
                    end
                    else
                    begin
                        acc_next   = MOD_W'(1);
                        base_next  = (cur_mod == MOD_W'(2)) ? '0 : MOD_W'(2);
                        e_next     = exp_reg[WORD_W-1:0];
                        state_next = S_POW_TEST;
                    end
                end
            end
            S_POW_TEST:
            begin
                if (e_reg == '0)
                begin
                    cache_next[idx_reg]  = acc_reg;
                    fvalid_next[idx_reg] = 1'b1;
                    mm_ctrl_next = '{start: 1'b1, top_bit: TOP_RESIDUE};
                    mm_a_next    = coefmod_reg;
                    mm_b_next    = COEF_W'(acc_reg);
                    state_next   = S_SCALE;
                end
                else if (e_reg[0])
                begin
                    mm_ctrl_next = '{start: 1'b1, top_bit: TOP_RESIDUE};
                    mm_a_next    = acc_reg;
                    mm_b_next    = COEF_W'(base_reg);
                    state_next   = S_POW_MUL;
                end
                else
                begin
                    mm_ctrl_next = '{start: 1'b1, top_bit: TOP_RESIDUE};
                    mm_a_next    = base_reg;
                    mm_b_next    = COEF_W'(base_reg);
                    state_next   = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (mm_done)
                begin
                    acc_next = mm_result;
                    // The last squaring is not needed once no exponent bits remain.
                    if (e_reg[WORD_W-1:1] != '0)
                    begin
                        mm_ctrl_next = '{start: 1'b1, top_bit: TOP_RESIDUE};
                        mm_a_next    = base_reg;
                        mm_b_next    = COEF_W'(base_reg);
                        state_next   = S_POW_SQR;
                    end
                    else
                    begin
                        e_next     = '0;
                        state_next = S_POW_TEST;
                    end
                end
            end
            S_POW_SQR:
            begin
                if (mm_done)
                begin
                    base_next  = mm_result;
                    e_next     = e_reg >> 1;
                    state_next = S_POW_TEST;
                end
            end
            S_SCALE:
            begin
                if (mm_done)
                begin
                    res_next   = mm_result;
                    err_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    scaled_next      = res_reg;
                    shift_error_next = err_reg;
                    last_out_next    = last_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            log_base_reg    <= WORD_W'(1);
            power_reg       <= '0;
            for (int i = 0; i < NUM_MODULI; i++)
            begin
                mod_reg[i]   <= MOD_W'(2);
                cache_reg[i] <= '0;
            end
            fvalid_reg      <= '0;
            coef_reg        <= '0;
            idx_reg         <= '0;
            last_reg        <= 1'b0;
            exp_reg         <= '0;
            coefmod_reg     <= '0;
            acc_reg         <= '0;
            base_reg        <= '0;
            e_reg           <= '0;
            res_reg         <= '0;
            err_reg         <= 1'b0;
            mm_ctrl_reg     <= '0;
            mm_a_reg        <= '0;
            mm_b_reg        <= '0;
            out_valid_reg   <= 1'b0;
            scaled_reg      <= '0;
            shift_error_reg <= 1'b0;
            last_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            log_base_reg    <= log_base_next;
            power_reg       <= power_next;
            mod_reg         <= mod_next;
            cache_reg       <= cache_next;
            fvalid_reg      <= fvalid_next;
            coef_reg        <= coef_next;
            idx_reg         <= idx_next;
            last_reg        <= last_next;
            exp_reg         <= exp_next;
            coefmod_reg     <= coefmod_next;
            acc_reg         <= acc_next;
            base_reg        <= base_next;
            e_reg           <= e_next;
            res_reg         <= res_next;
            err_reg         <= err_next;
            mm_ctrl_reg     <= mm_ctrl_next;
            mm_a_reg        <= mm_a_next;
            mm_b_reg        <= mm_b_next;
            out_valid_reg   <= out_valid_next;
            scaled_reg      <= scaled_next;
            shift_error_reg <= shift_error_next;
            last_out_reg    <= last_out_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign scaled      = scaled_reg;
    assign shift_error = shift_error_reg;
    assign last_out    = last_out_reg;

endmodule

### bench/rns_scale_checker.sv
module rns_scale_checker
    import rsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MOD_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [COEF_W-1:0]    coefficient,
    input  logic [MIDX_W-1:0]    modulus_index,
    input  logic                 last_of_poly,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [MOD_W-1:0]     scaled,
    input  logic                 shift_error,
    input  logic                 last_out,
    output int                   mismatch_count,
    output int                   results_waiting,
    output int                   results_checked,
    output int                   overflow_results
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MOD_W-1:0] scaled;
        logic             shift_error;
        logic             last_out;
    } scaled_result_t;

    logic [WORD_W-1:0]     log_base;
    logic [WORD_W-1:0]     digit_power;
    logic [MOD_W-1:0]      moduli [NUM_MODULI];
    logic [MOD_W-1:0]      factor_cache [NUM_MODULI];
    logic [NUM_MODULI-1:0] factor_known;
    scaled_result_t        awaited [$];

    function automatic logic [MOD_W-1:0] mod_product(input logic [MOD_W-1:0] a,
                                                     input logic [MOD_W-1:0] b,
                                                     input logic [MOD_W-1:0] q);
        logic [2*MOD_W-1:0] product;
        product = a * b;
        return MOD_W'(product % q);
    endfunction

    function automatic logic [MOD_W-1:0] power_of_two_mod(input logic [WORD_W-1:0] exponent,
                                                          input logic [MOD_W-1:0]  q);
        logic [MOD_W-1:0] acc;
        logic [MOD_W-1:0] base;
        acc  = MOD_W'(1) % q;
        base = MOD_W'(2) % q;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (exponent[i])
                acc = mod_product(acc, base, q);
            base = mod_product(base, base, q);
        end
        return acc;
    endfunction

    // Works out the result of one request and fills the factor cache on the first
    // request for a modulus since the last register write.
    function automatic scaled_result_t scale_coefficient(input logic [COEF_W-1:0] coef,
                                                         input logic [MIDX_W-1:0] index,
                                                         input logic              last);
        logic [EXP_W-1:0]  exponent;
        logic [MOD_W-1:0]  q;
        logic [MIDX_W-1:0] slot;
        scaled_result_t    r;
        slot = index;
        if (slot >= NUM_MODULI)
            slot = MIDX_W'(NUM_MODULI - 1);
        exponent      = EXP_W'(log_base) * EXP_W'(digit_power);
        q             = moduli[slot];
        r.scaled      = '0;
        r.shift_error = 1'b0;
        r.last_out    = last;
        if (exponent[EXP_W-1:WORD_W] != '0)
            r.shift_error = 1'b1;
        else if (q >= MOD_W'(2))
        begin
            if (!factor_known[slot])
            begin
                factor_cache[slot] = power_of_two_mod(exponent[WORD_W-1:0], q);
                factor_known[slot] = 1'b1;
            end
            r.scaled = mod_product(MOD_W'(coef % q), factor_cache[slot], q);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_result_t want;
        if (!rst_n)
        begin
            log_base    = WORD_W'(1);
            digit_power = '0;
            for (int i = 0; i < NUM_MODULI; i++)
            begin
                moduli[i]       = MOD_W'(2);
                factor_cache[i] = '0;
            end
            factor_known = '0;
            awaited.delete();
            mismatch_count   = 0;
            results_waiting  = 0;
            results_checked  = 0;
            overflow_results = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                // Writes to an index outside the register map leave the cache intact.
                case (cfg_index)
                    REG_LOG_BASE:
                    begin
                        log_base     = cfg_data[WORD_W-1:0];
                        factor_known = '0;
                    end
                    REG_DIGIT_POWER:
                    begin
                        digit_power  = cfg_data[WORD_W-1:0];
                        factor_known = '0;
                    end
                    REG_MODULUS_ZERO, REG_MODULUS_ONE, REG_MODULUS_TWO, REG_MODULUS_THREE:
                    begin
                        moduli[MIDX_W'(cfg_index - REG_MODULUS_ZERO)] = cfg_data;
                        factor_known = '0;
                    end
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"%0t: result with no request outstanding: ",
                                  "scaled=%h shift_error=%b last_out=%b"},
                                 $time, scaled, shift_error, last_out);
                end
                else
                begin
                    want = awaited.pop_front();
                    results_checked++;
                    if (want.shift_error)
                        overflow_results++;
                    if (scaled !== want.scaled || shift_error !== want.shift_error ||
                        last_out !== want.last_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: result %0d: expected scaled=%h shift_error=%b ",
                                      "last_out=%b, got scaled=%h shift_error=%b last_out=%b"},
                                     $time, results_checked, want.scaled, want.shift_error,
                                     want.last_out, scaled, shift_error, last_out);
                    end
                end
            end

            if (in_valid && !in_stall)
                awaited.insert(awaited.size(),
                               scale_coefficient(coefficient, modulus_index, last_of_poly));

            results_waiting = awaited.size();
        end
    end

endmodule

### bench/rns_scale_by_power_of_two_unit_test.sv
module rns_scale_by_power_of_two_unit_test;
    import rsp_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 5;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int HOLD_OFF_CYCLES = 1200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 96;

    // Indexes past the end of the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [MOD_W-1:0]  MOD_ALL_ONES  = '1;
    localparam logic [COEF_W-1:0] COEF_ALL_ONES = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MOD_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [COEF_W-1:0]    coefficient;
    logic [MIDX_W-1:0]    modulus_index;
    logic                 last_of_poly;
    logic                 out_valid;
    logic                 out_stall;
    logic [MOD_W-1:0]     scaled;
    logic                 shift_error;
    logic                 last_out;

    int mismatch_count;
    int results_waiting;
    int results_checked;
    int overflow_results;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_request   = 1'b0;
    bit hold_off_served    = 1'b0;
    int requests_sent      = 0;
    int settings_applied   = 0;
    int idle_cycles        = 0;

    logic [MOD_W-1:0] moduli_set [NUM_MODULI];

    always #(CLK_PERIOD / 2) clk = ~clk;

    rns_scale_by_power_of_two_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coefficient   (coefficient),
        .modulus_index (modulus_index),
        .last_of_poly  (last_of_poly),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled        (scaled),
        .shift_error   (shift_error),
        .last_out      (last_out)
    );

    rns_scale_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .coefficient      (coefficient),
        .modulus_index    (modulus_index),
        .last_of_poly     (last_of_poly),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .scaled           (scaled),
        .shift_error      (shift_error),
        .last_out         (last_out),
        .mismatch_count   (mismatch_count),
        .results_waiting  (results_waiting),
        .results_checked  (results_checked),
        .overflow_results (overflow_results)
    );

    // Receiver side: random stalls, or one long hold-off when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request && !hold_off_served)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_served = 1'b1;
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic [COEF_W-1:0] coef, input logic [MIDX_W-1:0] index,
                             input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        coefficient   <= coef;
        modulus_index <= index;
        last_of_poly  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stops offering requests and waits until every result has been taken.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [MOD_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
    endtask

    task automatic apply_settings(input logic [MOD_W-1:0] base_word,
                                  input logic [MOD_W-1:0] power_word,
                                  input logic [MOD_W-1:0] m0, input logic [MOD_W-1:0] m1,
                                  input logic [MOD_W-1:0] m2, input logic [MOD_W-1:0] m3);
        write_register(REG_LOG_BASE, base_word);
        write_register(REG_DIGIT_POWER, power_word);
        write_register(REG_MODULUS_ZERO, m0);
        write_register(REG_MODULUS_ONE, m1);
        write_register(REG_MODULUS_TWO, m2);
        write_register(REG_MODULUS_THREE, m3);
        @(negedge clk);
        cfg_write <= 1'b0;
        moduli_set[0] = m0;
        moduli_set[1] = m1;
        moduli_set[2] = m2;
        moduli_set[3] = m3;
        settings_applied++;
    endtask

    task automatic write_spare_register(input logic [CFG_IDX_W-1:0] index);
        write_register(index, MOD_W'({$urandom(), $urandom()}));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [MOD_W-1:0] random_modulus();
        logic [COEF_W-1:0] wide;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(9))
            0:       return MOD_W'($urandom_range(0, 1));
            1:       return MOD_W'($urandom_range(2, 7));
            2, 3:    return MOD_W'($urandom_range(3, 65535));
            4:       return MOD_ALL_ONES - MOD_W'($urandom_range(0, 4));
            5, 6:    return wide[MOD_W-1:0];
            default: return wide[MOD_W-1:0] >> $urandom_range(0, MOD_W - 2);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] random_coefficient(input logic [MIDX_W-1:0] index);
        case ($urandom_range(7))
            0:       return '0;
            1:       return COEF_ALL_ONES;
            2:       return COEF_W'($urandom_range(0, 1000));
            // Just around the modulus, where the reduction wraps.
            3:       return COEF_W'(moduli_set[index]) + COEF_W'($urandom_range(0, 2)) -
                            COEF_W'(1);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    initial
    begin
        logic [WORD_W-1:0] base_value;
        logic [WORD_W-1:0] power_value;
        logic [MOD_W-1:0]  base_word;
        logic [MOD_W-1:0]  power_word;
        logic [MIDX_W-1:0] index;
        int                shift;
        int                poly_len;
        int                sent_in_phase;
        bit                held_off;
        bit                paused;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_LOG_BASE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        coefficient   = '0;
        modulus_index = '0;
        last_of_poly  = 1'b0;
        for (int i = 0; i < NUM_MODULI; i++)
            moduli_set[i] = MOD_W'(2);
        held_off = 1'b0;
        paused   = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Settings after reset: all moduli two, exponent zero.
        send_item('0, MIDX_W'(0), 1'b0);
        send_item(COEF_ALL_ONES, MIDX_W'(1), 1'b0);
        send_item(64'h8000_0000_0000_0000, MIDX_W'(2), 1'b0);
        send_item(64'd5, MIDX_W'(3), 1'b1);

        // Largest exponent that still fits, the largest modulus, and moduli one and zero.
        settle_block();
        apply_settings(MOD_ALL_ONES, MOD_W'(1), MOD_ALL_ONES, MOD_W'(3), MOD_W'(1), MOD_W'(0));
        send_item(COEF_ALL_ONES, MIDX_W'(0), 1'b0);
        send_item(COEF_ALL_ONES, MIDX_W'(1), 1'b0);
        send_item(64'd12345, MIDX_W'(2), 1'b0);
        send_item(COEF_ALL_ONES, MIDX_W'(3), 1'b1);
        send_item(64'h1FFF_FFFF_FFFF_FFFE, MIDX_W'(0), 1'b0);
        send_item(64'h1FFF_FFFF_FFFF_FFFF, MIDX_W'(0), 1'b1);

        // Writes past the register map must not disturb the cached factors.
        settle_block();
        write_spare_register(REG_SPARE_LO);
        write_spare_register(REG_SPARE_HI);
        send_item(64'd7, MIDX_W'(0), 1'b0);
        send_item(COEF_ALL_ONES, MIDX_W'(1), 1'b1);

        // Exponent of exactly two to the 32: just out of range.
        settle_block();
        apply_settings(MOD_W'(32'h0001_0000), MOD_W'(32'h0001_0000), random_modulus(),
                       random_modulus(), random_modulus(), random_modulus());
        send_item(COEF_ALL_ONES, MIDX_W'(0), 1'b0);
        send_item(64'd1, MIDX_W'(3), 1'b1);

        // Zero base with the largest power gives a factor of one.
        settle_block();
        apply_settings(MOD_W'(0), MOD_W'(32'hFFFF_FFFF), MOD_W'(2), MOD_ALL_ONES,
                       61'h1000_0000_0000_0000, 61'h0_0000_0001_0000_0001);
        send_item(COEF_ALL_ONES, MIDX_W'(0), 1'b0);
        send_item(COEF_ALL_ONES, MIDX_W'(1), 1'b1);
        send_item(64'hDEAD_BEEF_0123_4567, MIDX_W'(2), 1'b0);
        send_item(64'hFFFF_FFFF_0000_0000, MIDX_W'(3), 1'b1);

        settle_block();
        apply_settings(MOD_ALL_ONES, MOD_ALL_ONES, moduli_set[0], moduli_set[1],
                       moduli_set[2], moduli_set[3]);
        send_item(COEF_ALL_ONES, MIDX_W'(2), 1'b1);

        settle_block();
        apply_settings(MOD_W'(2), MOD_W'(32'h7FFF_FFFF), MOD_W'(1000003), MOD_W'(65537),
                       MOD_W'(3), MOD_W'(5));
        send_item(COEF_ALL_ONES, MIDX_W'(0), 1'b0);
        send_item(64'd123456789, MIDX_W'(1), 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            if (phase < PHASES / 3)
            begin
                sender_idle_pct    = 21;
                receiver_stall_pct = 85;
            end
            else if (phase < 2 * PHASES / 3)
            begin
                sender_idle_pct    = 85;
                receiver_stall_pct = 21;
            end
            else
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end

            case ($urandom_range(5))
                0:
                begin
                    base_value  = $urandom();
                    power_value = $urandom();
                end
                1:
                begin
                    base_value  = $urandom_range(0, 64);
                    power_value = $urandom_range(0, 1 << 20);
                end
                2:
                begin
                    base_value  = '0;
                    power_value = $urandom();
                    if ($urandom_range(1))
                    begin
                        base_value  = $urandom();
                        power_value = '0;
                    end
                end
                3:
                begin
                    // Exponent right at the 32-bit boundary, on one side or the other.
                    shift       = $urandom_range(1, WORD_W - 1);
                    base_value  = WORD_W'(1) << shift;
                    power_value = WORD_W'((33'h1_0000_0000 >> shift) - $urandom_range(0, 1));
                end
                default:
                begin
                    base_value  = $urandom_range(1, 40);
                    power_value = $urandom_range(0, 100);
                end
            endcase
            base_word                   = MOD_W'({$urandom(), $urandom()});
            base_word[WORD_W-1:0]       = base_value;
            power_word                  = MOD_W'({$urandom(), $urandom()});
            power_word[WORD_W-1:0]      = power_value;
            apply_settings(base_word, power_word, random_modulus(), random_modulus(),
                           random_modulus(), random_modulus());
            if ($urandom_range(3) == 0)
                write_spare_register($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO);

            sent_in_phase = 0;
            while (sent_in_phase < ITEMS_PER_PHASE)
            begin
                // Keep offering requests while the receiver holds off, so the block backs up.
                if (phase == 1 && !held_off && sent_in_phase >= ITEMS_PER_PHASE / 2)
                begin
                    hold_off_request = 1'b1;
                    held_off         = 1'b1;
                end
                if (phase == 5 && !paused && sent_in_phase >= ITEMS_PER_PHASE / 2)
                begin
                    settle_block();
                    paused = 1'b1;
                end

                index = MIDX_W'($urandom_range(0, NUM_MODULI - 1));
                if ($urandom_range(4) != 0)
                begin
                    // A whole polynomial for one modulus, marked on its final coefficient.
                    poly_len = $urandom_range(1, 16);
                    for (int k = 0; k < poly_len; k++)
                        send_item(random_coefficient(index), index, k == poly_len - 1);
                    sent_in_phase += poly_len;
                end
                else
                begin
                    send_item(random_coefficient(index), index, 1'($urandom_range(1)));
                    sent_in_phase++;
                end
            end
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests under %0d register settings; %0d results checked,",
                 requests_sent, settings_applied, results_checked);
        $display("%0d of them with the exponent out of range, across a %0d-cycle %s",
                 overflow_results, HOLD_OFF_CYCLES,
                 "receiver hold-off and a full drain part-way through a run.");
        if (mismatch_count == 0 && results_waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_mulmod_unit.sv
hw/rtl/rns_scale_by_power_of_two_unit.sv
bench/rns_scale_checker.sv
bench/rns_scale_by_power_of_two_unit_test.sv
